// File: design/flag_byte_framer_xor_checksum_top_macros.svh
// Assertion macros for the flag byte framer.
`ifndef FLAG_BYTE_FRAMER_XOR_CHECKSUM_TOP_MACROS_SVH
`define FLAG_BYTE_FRAMER_XOR_CHECKSUM_TOP_MACROS_SVH

// Property checked on every clock outside reset.
`define FBF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent on one clock, consequent on the next.
`define FBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/fbf_pkg.sv
// Constants and types shared by the flag byte framer.
`default_nettype none
package fbf_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7e;
  localparam logic [7:0] ESC_BYTE     = 8'h7d;
  localparam logic [7:0] ESC_FOR_FLAG = 8'h02;
  localparam logic [7:0] ESC_FOR_ESC  = 8'h01;

  localparam int MAX_BEATS = 6;
  localparam int CNT_W     = 3;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } stuffed_t;

  function automatic stuffed_t stuff(input logic [7:0] b);
    stuffed_t s;
    s.two = 1'b0;
    s.b0  = b;
    s.b1  = b;
    if (b == FLAG_BYTE) begin
      s.two = 1'b1;
      s.b0  = ESC_BYTE;
      s.b1  = ESC_FOR_FLAG;
    end else if (b == ESC_BYTE) begin
      s.two = 1'b1;
      s.b0  = ESC_BYTE;
      s.b1  = ESC_FOR_ESC;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: design/flag_byte_framer_xor_checksum_top.sv
// Top level of the flag byte framer with stuffing and XOR checksum.
//
//  channel | signals                         | payload
//  --------+---------------------------------+-------------------------------------
//  in      | in_tvalid in_tready in_tlast    | tdata: data_byte; tlast: end_of_message
//  out     | out_tvalid out_tready out_tlast | tdata: line_byte; tlast: run_last;
//          | out_tuser                       | tuser: frame_done
//
// An input byte is held in an input register, then expanded in one pass into a beat
// buffer of 1 to 6 line bytes that drains one beat per cycle while out_tready is high.
// The input register can take the next byte while the buffer drains; the beat
// buffer drain sets the input rate.
// rst_n is synchronous and clears the frame state, checksum and valid flags.
// A stall on out_tready holds the current beat; the input register fills and
// in_tready drops until the buffer drains.
`default_nettype none
`include "flag_byte_framer_xor_checksum_top_macros.svh"
module flag_byte_framer_xor_checksum_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] line_byte
  output logic            out_tlast,
  output logic [0:0]      out_tuser   // [0] frame_done
);
  import fbf_pkg::*;

  logic       in_v_r, in_eom_r;
  logic [7:0] in_byte_r;
  logic       inside_r;
  logic [7:0] xor_r;
  logic       buf_v_r, buf_eom_r;
  logic [7:0] buf_r [MAX_BEATS];
  cnt_t       cnt_r, idx_r;

  logic       buf_last, beat_take, load, in_take;
  logic [7:0] base, csum;
  stuffed_t   ds, cs;
  cnt_t       p0, p1, n_nxt;
  logic [7:0] seq [MAX_BEATS];

  assign buf_last  = (idx_r == cnt_r - cnt_t'(1));
  assign beat_take = buf_v_r && out_tready;
  assign load      = in_v_r && (!buf_v_r || (beat_take && buf_last));
  assign in_tready = !in_v_r || load;
  assign in_take   = in_tvalid && in_tready;

  assign base = inside_r ? xor_r : 8'h00;
  assign csum = base ^ in_byte_r;
  assign ds   = stuff(in_byte_r);
  assign cs   = stuff(csum);
  assign p0   = inside_r ? cnt_t'(0) : cnt_t'(1);
  assign p1   = p0 + (ds.two ? cnt_t'(2) : cnt_t'(1));
  assign n_nxt = in_eom_r ? (p1 + (cs.two ? cnt_t'(3) : cnt_t'(2))) : p1;

  always_comb begin
    for (int k = 0; k < MAX_BEATS; k++) begin
      if (!inside_r && k == 0) begin
        seq[k] = FLAG_BYTE;
      end else if (cnt_t'(k) == p0) begin
        seq[k] = ds.b0;
      end else if (ds.two && cnt_t'(k) == p0 + cnt_t'(1)) begin
        seq[k] = ds.b1;
      end else if (cnt_t'(k) == p1) begin
        seq[k] = cs.b0;
      end else if (cs.two && cnt_t'(k) == p1 + cnt_t'(1)) begin
        seq[k] = cs.b1;
      end else begin
        seq[k] = FLAG_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      buf_v_r  <= 1'b0;
      inside_r <= 1'b0;
      xor_r    <= 8'h00;
      idx_r    <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_take) begin
        in_v_r    <= 1'b1;
        in_byte_r <= in_tdata;
        in_eom_r  <= in_tlast;
      end else if (load) begin
        in_v_r <= 1'b0;
      end
      if (load) begin
        buf_v_r   <= 1'b1;
        buf_eom_r <= in_eom_r;
        cnt_r     <= n_nxt;
        idx_r     <= '0;
        buf_r     <= seq;
        inside_r  <= !in_eom_r;
        xor_r     <= in_eom_r ? 8'h00 : csum;
      end else if (beat_take) begin
        if (buf_last) begin
          buf_v_r <= 1'b0;
        end else begin
          idx_r <= idx_r + cnt_t'(1);
        end
      end
    end
  end

  assign out_tvalid   = buf_v_r;
  assign out_tdata    = buf_r[idx_r];
  assign out_tlast    = buf_last;
  assign out_tuser[0] = buf_last && buf_eom_r;

  `FBF_ASSERT_ALWAYS(a_done_is_last, !(out_tvalid && out_tuser[0]) || out_tlast, "frame_done off last beat")
  `FBF_ASSERT_ALWAYS(a_idx_in_range, !buf_v_r || (idx_r < cnt_r), "beat index past count")
  `FBF_ASSERT_NEXT(a_drain_empty, beat_take && buf_last && !load, !out_tvalid, "buffer not empty after last beat")
  `FBF_ASSERT_NEXT(a_open_flag, load && !inside_r, out_tdata == FLAG_BYTE && idx_r == '0, "frame did not open with flag")

endmodule
`default_nettype wire
